### src/ile_pkg.sv
// ----------------------------------------------------------------------------
// ile_pkg - shared definitions for the indexed list engine
// Operation and status codes, port widths and parameter defaults.
// ----------------------------------------------------------------------------
package ile_pkg;

   localparam int DEPTH_DEFAULT       = 64;
   localparam int VALUE_WIDTH_DEFAULT = 32;
   localparam int WORD_WIDTH          = 32;  // width of value and read_value ports
   localparam int WIDE_WIDTH          = 64;  // widest stored value
   localparam int KIND_WIDTH          = 3;
   localparam int STATUS_WIDTH        = 2;

   typedef enum logic [KIND_WIDTH-1:0] {
      KIND_APPEND   = 3'd0,
      KIND_READ     = 3'd1,
      KIND_REMOVE   = 3'd2,
      KIND_INSERT   = 3'd3,
      KIND_CONTAINS = 3'd4,
      KIND_SWAP     = 3'd5
   } kind_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2,
      ST_EMPTY = 2'd3
   } status_type;

endpackage

### src/ile_ram.sv
// ----------------------------------------------------------------------------
// ile_ram - generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ile_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

### src/indexed_list_engine_unit.sv
// ----------------------------------------------------------------------------
// indexed_list_engine_unit - ordered list with indexed access
// Append, read, remove, insert, membership search and swap over a list of up
// to DEPTH words kept in one RAM, walked by a small sequencer.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+----------------------------------
//  req     | in        | req_valid/req_ready | kind, index_a, index_b, value
//  rsp     | out       | rsp_valid/rsp_ready | read_value, found, status, length
//
// Path of each operation from acceptance to the result register (S_FINISH):
//   append, or any rejected operation: straight to S_FINISH
//   read: S_FETCH, S_USE; swap: S_FETCH, S_USE twice, then S_PUT
//   remove at i: S_FETCH, S_USE per entry moved down (none at the last entry)
//   insert at i: S_FETCH, S_USE per entry moved up, then S_PUT (direct if i==count)
//   contains: S_FETCH, S_USE per entry visited up to and including the match
// The single RAM read port makes moved or searched entries go one at a time.
// Reset clears the list length and the handshake state; the RAM is not cleared,
// since no entry at or beyond the length is ever read.
// A finished result waits in the rsp register; the next req transfer is taken
// while it waits, and only the following result stalls on rsp_ready.
// ----------------------------------------------------------------------------
module indexed_list_engine_unit
   import ile_pkg::*;
#(
   parameter int DEPTH       = DEPTH_DEFAULT,
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   // request channel
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [KIND_WIDTH-1:0]      req_kind,
   input  logic [$clog2(DEPTH+1)-1:0] req_index_a,
   input  logic [$clog2(DEPTH)-1:0]   req_index_b,
   input  logic [WORD_WIDTH-1:0]      req_value,
   // response channel
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [WORD_WIDTH-1:0]      rsp_read_value,
   output logic                       rsp_found,
   output logic [STATUS_WIDTH-1:0]    rsp_status,
   output logic [$clog2(DEPTH+1)-1:0] rsp_length
);

   localparam int CW = $clog2(DEPTH + 1);   // count / position width
   localparam int AW = $clog2(DEPTH);       // RAM address width
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);
   localparam logic [CW-1:0] ONE        = CW'(1);

   // one-hot sequencer
   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_FETCH  = 5'b00010,   // RAM read address presented
      S_USE    = 5'b00100,   // RAM read data available
      S_PUT    = 5'b01000,   // final write of insert / swap
      S_FINISH = 5'b10000    // load result register
   } state_type;

   state_type              state_ff, state_in;
   logic [CW-1:0]          count_ff, count_in;
   kind_type               kind_ff, kind_in;
   logic [CW-1:0]          ia_ff, ia_in;
   logic [AW-1:0]          ib_ff, ib_in;
   logic [VALUE_WIDTH-1:0] val_ff, val_in;
   logic [VALUE_WIDTH-1:0] tmp_ff, tmp_in;
   logic [CW-1:0]          src_ff, src_in;
   logic [CW-1:0]          dst_ff, dst_in;
   logic                   phase_ff, phase_in;   // swap: first read done
   logic [WORD_WIDTH-1:0]  res_rd_ff, res_rd_in;
   logic                   res_found_ff, res_found_in;
   status_type             res_status_ff, res_status_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [WORD_WIDTH-1:0]  rsp_rd_ff, rsp_rd_in;
   logic                   rsp_found_ff, rsp_found_in;
   status_type             rsp_status_ff, rsp_status_in;
   logic [CW-1:0]          rsp_length_ff, rsp_length_in;

   // RAM port signals
   logic                   mem_we;
   logic [AW-1:0]          mem_waddr;
   logic [VALUE_WIDTH-1:0] mem_wdata;
   logic [AW-1:0]          mem_raddr;
   logic [VALUE_WIDTH-1:0] mem_rdata;

   // value width adaptation
   logic [WIDE_WIDTH-1:0]  req_value_wide;
   logic [VALUE_WIDTH-1:0] req_value_m;
   logic [WIDE_WIDTH-1:0]  rdata_wide;
   logic [CW-1:0]          ib_ext;
   logic [CW-1:0]          req_ia_inc;
   logic [CW-1:0]          src_inc;
   logic [CW-1:0]          src_dec;
   logic [CW-1:0]          dst_inc;
   logic [CW-1:0]          dst_dec;
   logic [CW-1:0]          count_inc;
   logic [CW-1:0]          count_dec;
   logic                   list_empty;
   logic                   list_full;

   ile_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   always_comb begin
      req_value_wide = '0;
      req_value_wide[WORD_WIDTH-1:0] = req_value;
      req_value_m = req_value_wide[VALUE_WIDTH-1:0];
      rdata_wide = '0;
      rdata_wide[VALUE_WIDTH-1:0] = mem_rdata;
      ib_ext = '0;
      ib_ext[AW-1:0] = req_index_b;
   end

   assign req_ia_inc = req_index_a + ONE;
   assign src_inc    = src_ff + ONE;
   assign src_dec    = src_ff - ONE;
   assign dst_inc    = dst_ff + ONE;
   assign dst_dec    = dst_ff - ONE;
   assign count_inc  = count_ff + ONE;
   assign count_dec  = count_ff - ONE;
   assign list_empty = (count_ff == '0);
   assign list_full  = (count_ff == FULL_COUNT);

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      kind_in       = kind_ff;
      ia_in         = ia_ff;
      ib_in         = ib_ff;
      val_in        = val_ff;
      tmp_in        = tmp_ff;
      src_in        = src_ff;
      dst_in        = dst_ff;
      phase_in      = phase_ff;
      res_rd_in     = res_rd_ff;
      res_found_in  = res_found_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_rd_in     = rsp_rd_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_status_in = rsp_status_ff;
      rsp_length_in = rsp_length_ff;
      mem_we        = 1'b0;
      mem_waddr     = src_ff[AW-1:0];
      mem_wdata     = mem_rdata;
      mem_raddr     = src_ff[AW-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               kind_in       = kind_type'(req_kind);
               ia_in         = req_index_a;
               ib_in         = req_index_b;
               val_in        = req_value_m;
               res_rd_in     = '0;
               res_found_in  = 1'b0;
               res_status_in = ST_OK;
               phase_in      = 1'b0;
               state_in      = S_FINISH;
               case (req_kind)
                  KIND_APPEND: begin
                     if (list_full) begin
                        res_status_in = ST_FULL;
                     end else begin
                        mem_we    = 1'b1;
                        mem_waddr = count_ff[AW-1:0];
                        mem_wdata = req_value_m;
                        count_in  = count_inc;
                     end
                  end
                  KIND_READ: begin
                     if (list_empty) begin
                        res_status_in = ST_EMPTY;
                     end else if (req_index_a >= count_ff) begin
                        // past the end: return the last entry, flagged
                        res_status_in = ST_RANGE;
                        src_in        = count_dec;
                        state_in      = S_FETCH;
                     end else begin
                        src_in   = req_index_a;
                        state_in = S_FETCH;
                     end
                  end
                  KIND_REMOVE: begin
                     if (list_empty) begin
                        res_status_in = ST_EMPTY;
                     end else if (req_index_a >= count_ff) begin
                        res_status_in = ST_RANGE;
                     end else if (req_ia_inc < count_ff) begin
                        src_in   = req_ia_inc;
                        dst_in   = req_index_a;
                        state_in = S_FETCH;
                     end else begin
                        count_in = count_dec;   // last entry: nothing to close up
                     end
                  end
                  KIND_INSERT: begin
                     if (req_index_a > count_ff) begin
                        res_status_in = ST_RANGE;
                     end else if (list_full) begin
                        res_status_in = ST_FULL;
                     end else if (req_index_a == count_ff) begin
                        mem_we    = 1'b1;
                        mem_waddr = req_index_a[AW-1:0];
                        mem_wdata = req_value_m;
                        count_in  = count_inc;
                     end else begin
                        src_in   = count_dec;
                        dst_in   = count_ff;
                        state_in = S_FETCH;
                     end
                  end
                  KIND_CONTAINS: begin
                     if (!list_empty) begin
                        src_in   = '0;
                        state_in = S_FETCH;
                     end
                  end
                  KIND_SWAP: begin
                     if (list_empty) begin
                        res_status_in = ST_EMPTY;
                     end else if (req_index_a >= count_ff || ib_ext >= count_ff) begin
                        res_status_in = ST_RANGE;
                     end else begin
                        src_in   = req_index_a;
                        state_in = S_FETCH;
                     end
                  end
                  default: begin
                     // unused codes: no change, plain ok
                  end
               endcase
            end
         end

         S_FETCH: begin
            mem_raddr = src_ff[AW-1:0];
            state_in  = S_USE;
         end

         S_USE: begin
            state_in = S_FINISH;
            case (kind_ff)
               KIND_READ: begin
                  res_rd_in = rdata_wide[WORD_WIDTH-1:0];
               end
               KIND_REMOVE: begin
                  mem_we    = 1'b1;
                  mem_waddr = dst_ff[AW-1:0];
                  mem_wdata = mem_rdata;
                  if (src_inc < count_ff) begin
                     src_in   = src_inc;
                     dst_in   = dst_inc;
                     state_in = S_FETCH;
                  end else begin
                     count_in = count_dec;
                  end
               end
               KIND_INSERT: begin
                  mem_we    = 1'b1;
                  mem_waddr = dst_ff[AW-1:0];
                  mem_wdata = mem_rdata;
                  if (src_ff > ia_ff) begin
                     src_in   = src_dec;
                     dst_in   = dst_dec;
                     state_in = S_FETCH;
                  end else begin
                     state_in = S_PUT;
                  end
               end
               KIND_CONTAINS: begin
                  if (mem_rdata == val_ff) begin
                     res_found_in = 1'b1;
                  end else if (src_inc < count_ff) begin
                     src_in   = src_inc;
                     state_in = S_FETCH;
                  end
               end
               KIND_SWAP: begin
                  if (!phase_ff) begin
                     tmp_in   = mem_rdata;
                     src_in   = '0;
                     src_in[AW-1:0] = ib_ff;
                     phase_in = 1'b1;
                     state_in = S_FETCH;
                  end else begin
                     mem_we    = 1'b1;
                     mem_waddr = ia_ff[AW-1:0];
                     mem_wdata = mem_rdata;
                     state_in  = S_PUT;
                  end
               end
               default: begin
               end
            endcase
         end

         S_PUT: begin
            mem_we   = 1'b1;
            state_in = S_FINISH;
            if (kind_ff == KIND_INSERT) begin
               mem_waddr = ia_ff[AW-1:0];
               mem_wdata = val_ff;
               count_in  = count_inc;
            end else begin
               mem_waddr = ib_ff;
               mem_wdata = tmp_ff;
            end
         end

         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_rd_in     = res_rd_ff;
               rsp_found_in  = res_found_ff;
               rsp_status_in = res_status_ff;
               rsp_length_in = count_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff       <= kind_in;
      ia_ff         <= ia_in;
      ib_ff         <= ib_in;
      val_ff        <= val_in;
      tmp_ff        <= tmp_in;
      src_ff        <= src_in;
      dst_ff        <= dst_in;
      phase_ff      <= phase_in;
      res_rd_ff     <= res_rd_in;
      res_found_ff  <= res_found_in;
      res_status_ff <= res_status_in;
      rsp_rd_ff     <= rsp_rd_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_status_ff <= rsp_status_in;
      rsp_length_ff <= rsp_length_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_rd_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_length     = rsp_length_ff;

endmodule

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb - self-checking bench for indexed_list_engine_unit
// Every op is predicted by a shadow copy of the list. Each response is checked
// against the oldest prediction. A short table of corner cases runs first.
// Phased random traffic follows, growing and shrinking the list between empty
// and full. Both channels are throttled at random.
// ----------------------------------------------------------------------------
module tb;
   import ile_pkg::*;

   localparam int LIST_DEPTH     = DEPTH_DEFAULT;
   localparam int LEN_W          = $clog2(LIST_DEPTH + 1);
   localparam int SEL_W          = $clog2(LIST_DEPTH);
   localparam int RANDOM_OPS     = 1000;   // counted ops after the table
   localparam int WATCHDOG_LIMIT = 2000;   // cycles with no transfer on either side
   localparam int DRAIN_CYCLES   = 150;    // quiet tail after the last response
   localparam int REPORT_MAX     = 10;

   // opcodes the package leaves unnamed; the block must treat them as no-ops
   localparam logic [KIND_WIDTH-1:0] KIND_SPARE6 = 3'd6;
   localparam logic [KIND_WIDTH-1:0] KIND_SPARE7 = 3'd7;

   typedef struct packed {
      logic [WORD_WIDTH-1:0] read_value;
      logic                  found;
      status_type            status;
      logic [LEN_W-1:0]      length;
   } list_result_type;

   // one row of the corner-case table; reps > 1 repeats the op with value + n
   typedef struct packed {
      logic [KIND_WIDTH-1:0] kind;
      logic [LEN_W-1:0]      index_a;
      logic [SEL_W-1:0]      index_b;
      logic [WORD_WIDTH-1:0] value;
      logic [7:0]            reps;
      logic                  pinned;   // outcome below is typed in, not predicted
      list_result_type       outcome;
   } corner_row_type;

   typedef enum logic [1:0] {MIX_GROW, MIX_SHRINK, MIX_BALANCED} mix_phase_type;

   // ---------------------------------------------------------------- DUT ports
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [KIND_WIDTH-1:0] req_kind = '0;
   logic [LEN_W-1:0]      req_index_a = '0;
   logic [SEL_W-1:0]      req_index_b = '0;
   logic [WORD_WIDTH-1:0] req_value = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [WORD_WIDTH-1:0] rsp_read_value;
   logic                  rsp_found;
   logic [STATUS_WIDTH-1:0] rsp_status;
   logic [LEN_W-1:0]      rsp_length;

   indexed_list_engine_unit u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_kind       (req_kind),
      .req_index_a    (req_index_a),
      .req_index_b    (req_index_b),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_read_value (rsp_read_value),
      .rsp_found      (rsp_found),
      .rsp_status     (rsp_status),
      .rsp_length     (rsp_length)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------- bench state
   logic [WORD_WIDTH-1:0] shadow_list [LIST_DEPTH];  // predicted list contents
   int                    shadow_len = 0;
   list_result_type       outcome_fifo [$];          // predictions awaiting a response
   list_result_type       staged_outcome;            // prediction for the op on req_*
   corner_row_type        corner_rows [$];
   mix_phase_type         mix_phase = MIX_GROW;
   int                    phase_left = 0;
   int                    burst_left = 0;
   int                    ready_mode = 0;
   int                    ready_left = 0;
   int                    fail_count = 0;
   int                    req_transfers = 0;
   int                    rsp_transfers = 0;
   int                    idle_cycles = 0;
   int                    cycle_count = 0;
   int                    full_hits = 0;
   int                    empty_hits = 0;
   int                    kind_hits [8];

   // ---------------------------------------------------------------- predictor
   // Applies one op to the shadow list and returns the response it must cause.
   function automatic list_result_type apply_list_op(input logic [KIND_WIDTH-1:0] kind,
                                                     input logic [LEN_W-1:0] ia,
                                                     input logic [SEL_W-1:0] ib,
                                                     input logic [WORD_WIDTH-1:0] value);
      list_result_type       res;
      logic [WORD_WIDTH-1:0] held;
      int                    i;
      res = '0;
      res.status = ST_OK;
      case (kind)
         KIND_APPEND: begin
            if (shadow_len >= LIST_DEPTH) begin
               res.status = ST_FULL;
            end else begin
               shadow_list[shadow_len] = value;
               shadow_len++;
            end
         end
         KIND_READ: begin
            if (shadow_len == 0) begin
               res.status = ST_EMPTY;
            end else if (ia >= shadow_len) begin
               // past the end: last entry comes back, flagged
               res.read_value = shadow_list[shadow_len - 1];
               res.status = ST_RANGE;
            end else begin
               res.read_value = shadow_list[ia];
            end
         end
         KIND_REMOVE: begin
            if (shadow_len == 0) begin
               res.status = ST_EMPTY;
            end else if (ia >= shadow_len) begin
               res.status = ST_RANGE;
            end else begin
               for (i = ia; i + 1 < shadow_len; i++) shadow_list[i] = shadow_list[i + 1];
               shadow_len--;
            end
         end
         KIND_INSERT: begin
            // range is checked ahead of fullness
            if (ia > shadow_len) begin
               res.status = ST_RANGE;
            end else if (shadow_len >= LIST_DEPTH) begin
               res.status = ST_FULL;
            end else begin
               for (i = shadow_len; i > ia; i--) shadow_list[i] = shadow_list[i - 1];
               shadow_list[ia] = value;
               shadow_len++;
            end
         end
         KIND_CONTAINS: begin
            for (i = 0; i < shadow_len; i++) begin
               if (shadow_list[i] == value) res.found = 1'b1;
            end
         end
         KIND_SWAP: begin
            if (shadow_len == 0) begin
               res.status = ST_EMPTY;
            end else if (ia >= shadow_len || ib >= shadow_len) begin
               res.status = ST_RANGE;
            end else begin
               held = shadow_list[ia];
               shadow_list[ia] = shadow_list[ib];
               shadow_list[ib] = held;
            end
         end
         default: ;
      endcase
      res.length = shadow_len[LEN_W-1:0];
      return res;
   endfunction

   // ------------------------------------------------------------------- sender
   // Drives one op and returns at the falling edge after its transfer. The
   // sender runs in bursts; between bursts valid drops and the payload is junk.
   task automatic send_op(input logic [KIND_WIDTH-1:0] kind, input logic [LEN_W-1:0] ia,
                          input logic [SEL_W-1:0] ib, input logic [WORD_WIDTH-1:0] value,
                          input logic pinned, input list_result_type pinned_outcome);
      list_result_type predicted;
      int              prev_len;
      int              gap;
      prev_len = shadow_len;
      predicted = apply_list_op(kind, ia, ib, value);
      kind_hits[kind]++;
      if (shadow_len == LIST_DEPTH && prev_len != LIST_DEPTH) full_hits++;
      if (shadow_len == 0 && prev_len != 0) empty_hits++;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         repeat (gap) begin
            req_valid   <= 1'b0;
            req_kind    <= KIND_WIDTH'($urandom_range(0, 7));
            req_index_a <= LEN_W'($urandom_range(0, 127));
            req_index_b <= SEL_W'($urandom_range(0, 63));
            req_value   <= $urandom;
            @(negedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      staged_outcome = pinned ? pinned_outcome : predicted;
      req_valid   <= 1'b1;
      req_kind    <= kind;
      req_index_a <= ia;
      req_index_b <= ib;
      req_value   <= value;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic add_row(input logic [KIND_WIDTH-1:0] kind, input int ia, input int ib,
                          input logic [WORD_WIDTH-1:0] value, input int reps,
                          input logic pinned, input logic [WORD_WIDTH-1:0] rd,
                          input logic fnd, input status_type st, input int len);
      corner_row_type row;
      row.kind               = kind;
      row.index_a            = ia[LEN_W-1:0];
      row.index_b            = ib[SEL_W-1:0];
      row.value              = value;
      row.reps               = reps[7:0];
      row.pinned             = pinned;
      row.outcome.read_value = rd;
      row.outcome.found      = fnd;
      row.outcome.status     = st;
      row.outcome.length     = len[LEN_W-1:0];
      corner_rows.push_back(row);
   endtask

   // Index picker: mostly in range, some at the edges, some anywhere in 7 bits.
   function automatic logic [LEN_W-1:0] pick_index(input int span);
      int roll;
      roll = $urandom_range(0, 99);
      if (span > 0 && roll < 80) return LEN_W'($urandom_range(0, span - 1));
      if (roll < 92) begin
         case ($urandom_range(0, 3))
            0:       return span[LEN_W-1:0];
            1:       return (span > 0) ? LEN_W'(span - 1) : '0;
            2:       return LEN_W'(LIST_DEPTH);
            default: return LEN_W'(LIST_DEPTH - 1);
         endcase
      end
      return LEN_W'($urandom_range(0, 127));
   endfunction

   // Search keys and stored words: a small pool so duplicates occur, the
   // extremes, words already in the list, and full-width random words.
   function automatic logic [WORD_WIDTH-1:0] pick_value(input logic from_list);
      int roll;
      roll = $urandom_range(0, 99);
      if (from_list && shadow_len > 0 && roll < 60)
         return shadow_list[$urandom_range(0, shadow_len - 1)];
      if (roll < 72) return WORD_WIDTH'($urandom_range(0, 15));
      if (roll < 76) return '0;
      if (roll < 80) return '1;
      return $urandom;
   endfunction

   // Phased random op; returns 1 when the op is one the block acts on.
   task automatic send_random_op(output logic counted);
      logic [KIND_WIDTH-1:0] kind;
      logic [LEN_W-1:0]      ia;
      logic [SEL_W-1:0]      ib;
      int                    roll;
      list_result_type       unused;
      // steer the list between the empty and full extremes
      if (phase_left == 0 || (mix_phase == MIX_GROW && shadow_len == LIST_DEPTH)
          || (mix_phase == MIX_SHRINK && shadow_len == 0)) begin
         if (shadow_len == LIST_DEPTH)  mix_phase = MIX_SHRINK;
         else if (shadow_len == 0)      mix_phase = MIX_GROW;
         else                           mix_phase = mix_phase_type'($urandom_range(0, 2));
         phase_left = $urandom_range(20, 90);
      end
      phase_left--;
      roll = $urandom_range(0, 99);
      case (mix_phase)
         MIX_GROW:
            kind = (roll < 35) ? KIND_APPEND : (roll < 70) ? KIND_INSERT :
                   (roll < 80) ? KIND_READ : (roll < 88) ? KIND_CONTAINS :
                   (roll < 94) ? KIND_SWAP : (roll < 98) ? KIND_REMOVE : KIND_SPARE6;
         MIX_SHRINK:
            kind = (roll < 55) ? KIND_REMOVE : (roll < 67) ? KIND_READ :
                   (roll < 77) ? KIND_CONTAINS : (roll < 85) ? KIND_SWAP :
                   (roll < 91) ? KIND_APPEND : (roll < 98) ? KIND_INSERT : KIND_SPARE7;
         default:
            kind = (roll < 17) ? KIND_APPEND : (roll < 34) ? KIND_INSERT :
                   (roll < 56) ? KIND_REMOVE : (roll < 72) ? KIND_READ :
                   (roll < 86) ? KIND_CONTAINS : (roll < 98) ? KIND_SWAP :
                   (roll < 99) ? KIND_SPARE6 : KIND_SPARE7;
      endcase
      ia = pick_index((kind == KIND_INSERT) ? shadow_len + 1 : shadow_len);
      ib = (shadow_len > 0 && $urandom_range(0, 99) < 85)
           ? SEL_W'($urandom_range(0, shadow_len - 1))
           : SEL_W'($urandom_range(0, 63));
      unused = '0;
      send_op(kind, ia, ib, pick_value(kind == KIND_CONTAINS), 1'b0, unused);
      counted = (kind != KIND_SPARE6 && kind != KIND_SPARE7);
   endtask

   // ----------------------------------------------------------------- receiver
   // Ready follows a pattern of its own: stretches always ready, stretches
   // of coin-flip stalls, and stretches that are mostly stalled.
   always @(negedge clock) begin
      if (ready_left == 0) begin
         ready_mode <= $urandom_range(0, 2);
         ready_left <= $urandom_range(10, 60);
      end else begin
         ready_left <= ready_left - 1;
      end
      case (ready_mode)
         0:       rsp_ready <= 1'b1;
         1:       rsp_ready <= 1'($urandom_range(0, 1));
         default: rsp_ready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   // ------------------------------------------------------- monitor and check
   // Responses are checked before the request push so that a response can
   // never be matched to a request taken on the same edge.
   always @(posedge clock) begin
      list_result_type want;
      list_result_type got;
      if (!reset) begin
         cycle_count++;
         if (rsp_valid && rsp_ready) begin
            rsp_transfers++;
            got.read_value = rsp_read_value;
            got.found      = rsp_found;
            got.status     = status_type'(rsp_status);
            got.length     = rsp_length;
            if (outcome_fifo.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_MAX)
                  $display("[%0t] response with no op outstanding: rd=%h found=%0d st=%0d len=%0d",
                           $realtime, got.read_value, got.found, got.status, got.length);
            end else begin
               want = outcome_fifo.pop_front();
               if (got.read_value !== want.read_value || got.found !== want.found ||
                   got.status !== want.status || got.length !== want.length) begin
                  fail_count++;
                  if (fail_count <= REPORT_MAX)
                     $display("[%0t] response %0d mismatch: exp rd=%h found=%0d st=%0d len=%0d, got rd=%h found=%0d st=%0d len=%0d",
                              $realtime, rsp_transfers, want.read_value, want.found,
                              want.status, want.length, got.read_value, got.found,
                              got.status, got.length);
               end
            end
         end
         if (req_valid && req_ready) begin
            req_transfers++;
            outcome_fifo.push_back(staged_outcome);
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d responses outstanding",
                     idle_cycles, outcome_fifo.size());
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // -------------------------------------------------------------- main flow
   initial begin
      logic            counted;
      int              done_ops;
      int              r;
      corner_row_type  row;
      foreach (kind_hits[k]) kind_hits[k] = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Corner table. Pinned rows carry the outcome read straight off the
      // op's rules; the rest are predicted.
      // empty list: every op that needs an entry reports empty, search finds nothing
      add_row(KIND_READ,     0,   0, 32'h0,         1, 1, 32'h0,         0, ST_EMPTY, 0);
      add_row(KIND_REMOVE,   0,   0, 32'h0,         1, 1, 32'h0,         0, ST_EMPTY, 0);
      add_row(KIND_SWAP,     0,   0, 32'h0,         1, 1, 32'h0,         0, ST_EMPTY, 0);
      add_row(KIND_CONTAINS, 0,   0, 32'h0,         1, 1, 32'h0,         0, ST_OK,    0);
      add_row(KIND_INSERT,   1,   0, 32'h1,         1, 1, 32'h0,         0, ST_RANGE, 0);
      // insert at 0 is a true prepend, also into a non-empty list
      add_row(KIND_INSERT,   0,   0, 32'hA5A5_0001, 1, 1, 32'h0,         0, ST_OK,    1);
      add_row(KIND_APPEND,   0,   0, 32'hFFFF_FFFF, 1, 1, 32'h0,         0, ST_OK,    2);
      add_row(KIND_APPEND,   0,   0, 32'h0,         1, 1, 32'h0,         0, ST_OK,    3);
      add_row(KIND_INSERT,   0,   0, 32'h1234_5678, 1, 1, 32'h0,         0, ST_OK,    4);
      add_row(KIND_READ,     0,   0, 32'h0,         1, 1, 32'h1234_5678, 0, ST_OK,    4);
      // read past the end hands back the last entry
      add_row(KIND_READ,     127, 0, 32'h0,         1, 1, 32'h0,         0, ST_RANGE, 4);
      add_row(KIND_SWAP,     0,   3, 32'h0,         1, 0, 32'h0,         0, ST_OK,    0);
      add_row(KIND_READ,     64,  0, 32'h0,         1, 1, 32'h1234_5678, 0, ST_RANGE, 4);
      add_row(KIND_SWAP,     1,   63, 32'h0,        1, 1, 32'h0,         0, ST_RANGE, 4);
      add_row(KIND_CONTAINS, 0,   0, 32'hFFFF_FFFF, 1, 1, 32'h0,         1, ST_OK,    4);
      add_row(KIND_CONTAINS, 0,   0, 32'h1,         1, 0, 32'h0,         0, ST_OK,    0);
      add_row(KIND_REMOVE,   4,   0, 32'h0,         1, 1, 32'h0,         0, ST_RANGE, 4);
      add_row(KIND_REMOVE,   0,   0, 32'h0,         1, 0, 32'h0,         0, ST_OK,    0);
      add_row(KIND_INSERT,   4,   0, 32'h2,         1, 1, 32'h0,         0, ST_RANGE, 3);
      add_row(KIND_INSERT,   3,   0, 32'hDEAD_BEEF, 1, 0, 32'h0,         0, ST_OK,    0);
      // unused opcodes change nothing
      add_row(KIND_SPARE6,   5,   5, 32'h5,         1, 1, 32'h0,         0, ST_OK,    4);
      add_row(KIND_SPARE7,   127, 63, 32'hFFFF_FFFF, 1, 1, 32'h0,        0, ST_OK,    4);
      // fill to capacity, then the full-list rejections
      add_row(KIND_APPEND,   0,   0, 32'h8000_0000, 60, 0, 32'h0,        0, ST_OK,    0);
      add_row(KIND_APPEND,   0,   0, 32'h3,         1, 1, 32'h0,         0, ST_FULL,  64);
      add_row(KIND_INSERT,   64,  0, 32'h4,         1, 1, 32'h0,         0, ST_FULL,  64);
      add_row(KIND_INSERT,   65,  0, 32'h4,         1, 1, 32'h0,         0, ST_RANGE, 64);
      add_row(KIND_SWAP,     63,  0, 32'h0,         1, 0, 32'h0,         0, ST_OK,    0);
      add_row(KIND_READ,     63,  0, 32'h0,         1, 0, 32'h0,         0, ST_OK,    0);
      add_row(KIND_REMOVE,   63,  0, 32'h0,         1, 0, 32'h0,         0, ST_OK,    0);
      add_row(KIND_REMOVE,   0,   0, 32'h0,         63, 0, 32'h0,        0, ST_OK,    0);
      // stale words left in storage must not be seen once the list is empty
      add_row(KIND_CONTAINS, 0,   0, 32'h8000_0005, 1, 1, 32'h0,         0, ST_OK,    0);
      add_row(KIND_READ,     0,   0, 32'h0,         1, 1, 32'h0,         0, ST_EMPTY, 0);

      foreach (corner_rows[i]) begin
         row = corner_rows[i];
         for (r = 0; r < row.reps; r++)
            send_op(row.kind, row.index_a, row.index_b, row.value + r, row.pinned,
                    row.outcome);
      end

      done_ops = 0;
      while (done_ops < RANDOM_OPS) begin
         send_random_op(counted);
         if (counted) done_ops++;
      end
      req_valid <= 1'b0;

      // drain: every prediction answered, then a quiet tail for strays
      while (outcome_fifo.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d transfers in %0d cycles: append %0d, read %0d, remove %0d, insert %0d, contains %0d, swap %0d, unused %0d",
               req_transfers, cycle_count, kind_hits[KIND_APPEND], kind_hits[KIND_READ],
               kind_hits[KIND_REMOVE], kind_hits[KIND_INSERT], kind_hits[KIND_CONTAINS],
               kind_hits[KIND_SWAP], kind_hits[KIND_SPARE6] + kind_hits[KIND_SPARE7]);
      $display("List filled %0d times and emptied %0d times; %0d responses checked, %0d mismatches",
               full_hits, empty_hits, rsp_transfers, fail_count);
      if (fail_count == 0 && outcome_fifo.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

### files.f
src/ile_pkg.sv
src/ile_ram.sv
src/indexed_list_engine_unit.sv
verif/tb.sv
